### rtl/gpio_port_with_config_lock_top_macros.svh
// Assertion macros shared by the GPIO port RTL.
// No dependencies; included by modules that carry concurrent assertions.
`ifndef GPIO_PORT_WITH_CONFIG_LOCK_TOP_MACROS_SVH
`define GPIO_PORT_WITH_CONFIG_LOCK_TOP_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define GPL_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

// Consequent must hold in the same cycle as the antecedent.
`define GPL_ASSERT_SAME(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`endif

### rtl/gpl_pkg.sv
// Package for the GPIO port with configuration lock: item types, register
// selector codes, key sequence codes and the lock field mask helper. No dependencies.
`default_nettype none

package gpl_pkg;

    localparam logic [2:0] REG_CRL    = 3'd0;
    localparam logic [2:0] REG_CRH    = 3'd1;
    localparam logic [2:0] REG_IDR    = 3'd2;
    localparam logic [2:0] REG_ODR    = 3'd3;
    localparam logic [2:0] REG_BSRR   = 3'd4;
    localparam logic [2:0] REG_BRR    = 3'd5;
    localparam logic [2:0] REG_LCKR   = 3'd6;
    localparam logic [2:0] REG_UNUSED = 3'd7;

    localparam logic CMD_READ  = 1'b0;
    localparam logic CMD_WRITE = 1'b1;

    localparam logic [1:0] KEY_IDLE      = 2'd0;
    localparam logic [1:0] KEY_SAW_ONE   = 2'd1;
    localparam logic [1:0] KEY_SAW_ZERO  = 2'd2;

    localparam logic [31:0] CONFIG_RESET = 32'h4444_4444;
    localparam int          LCKK_POS     = 16;

    typedef struct packed {
        logic        cmd;
        logic [2:0]  reg_index;
        logic [31:0] write_data;
        logic [15:0] pin_levels;
    } gpl_in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic [15:0] pin_drive;
        logic [63:0] pad_config;
        logic        lock_active;
    } gpl_out_t;

    // Expand eight lock bits into a mask covering their 4-bit config fields.
    function automatic logic [31:0] field_mask_of(input logic [7:0] eight_bits);
        logic [31:0] m;
        m = '0;
        for (int p = 0; p < 8; p++) begin
            if (eight_bits[p]) begin
                m[4*p +: 4] = 4'hf;
            end
        end
        return m;
    endfunction

endpackage

`default_nettype wire

### rtl/gpl_core.sv
// Register file and lock key logic of the GPIO port: updates the state for
// one item per step and forms its result. Depends on gpl_pkg and the macro header.
`default_nettype none
`include "gpio_port_with_config_lock_top_macros.svh"

module gpl_core
    import gpl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     step,
    input  wire gpl_in_t  item,
    output gpl_out_t      result
);

    logic [31:0] config_low_reg,  config_low_next;
    logic [31:0] config_high_reg, config_high_next;
    logic [15:0] output_data_reg, output_data_next;
    logic [15:0] lock_bits_reg,   lock_bits_next;
    logic        lock_key_reg,    lock_key_next;
    logic [1:0]  key_phase_reg,   key_phase_next;
    logic        read_seen_reg,   read_seen_next;

    logic [31:0] keep_low;
    logic [31:0] keep_high;
    logic        same_bits;
    logic [31:0] rd;

    // Locked pins keep their fields only once the key is set.
    assign keep_low  = lock_key_reg ? field_mask_of(lock_bits_reg[7:0])  : '0;
    assign keep_high = lock_key_reg ? field_mask_of(lock_bits_reg[15:8]) : '0;
    assign same_bits = (item.write_data[15:0] == lock_bits_reg);

    always_comb begin
        config_low_next  = config_low_reg;
        config_high_next = config_high_reg;
        output_data_next = output_data_reg;
        lock_bits_next   = lock_bits_reg;
        lock_key_next    = lock_key_reg;
        key_phase_next   = key_phase_reg;
        read_seen_next   = read_seen_reg;
        rd               = '0;
        if (item.cmd == CMD_WRITE) begin
            case (item.reg_index)
                REG_CRL: begin
                    config_low_next = (config_low_reg & keep_low)
                                    | (item.write_data & ~keep_low);
                end
                REG_CRH: begin
                    config_high_next = (config_high_reg & keep_high)
                                     | (item.write_data & ~keep_high);
                end
                REG_ODR: begin
                    output_data_next = item.write_data[15:0];
                end
                REG_BSRR: begin
                    output_data_next = (output_data_reg & ~item.write_data[31:16])
                                     | item.write_data[15:0];
                end
                REG_BRR: begin
                    output_data_next = output_data_reg & ~item.write_data[15:0];
                end
                REG_LCKR: begin
                    if (!lock_key_reg) begin
                        if (item.write_data[LCKK_POS]) begin
                            if (key_phase_reg == KEY_SAW_ZERO && same_bits) begin
                                lock_key_next  = 1'b1;
                                key_phase_next = KEY_IDLE;
                                read_seen_next = 1'b0;
                            end else begin
                                key_phase_next = KEY_SAW_ONE;
                            end
                        end else begin
                            key_phase_next = (key_phase_reg == KEY_SAW_ONE && same_bits)
                                           ? KEY_SAW_ZERO : KEY_IDLE;
                        end
                        lock_bits_next = item.write_data[15:0];
                    end
                end
                default: begin
                end
            endcase
        end else begin
            case (item.reg_index)
                REG_CRL:  rd = config_low_reg;
                REG_CRH:  rd = config_high_reg;
                REG_IDR:  rd = {16'b0, item.pin_levels};
                REG_ODR:  rd = {16'b0, output_data_reg};
                REG_LCKR: begin
                    // LCKK reads back as zero on the first read after locking.
                    rd = {15'b0, lock_key_reg & read_seen_reg, lock_bits_reg};
                    if (lock_key_reg) begin
                        read_seen_next = 1'b1;
                    end
                end
                default:  rd = '0;
            endcase
        end
    end

    always_comb begin
        result.read_data   = rd;
        result.pin_drive   = output_data_next;
        result.pad_config  = {config_high_next, config_low_next};
        result.lock_active = lock_key_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            config_low_reg  <= CONFIG_RESET;
            config_high_reg <= CONFIG_RESET;
            output_data_reg <= '0;
            lock_bits_reg   <= '0;
            lock_key_reg    <= 1'b0;
            key_phase_reg   <= KEY_IDLE;
            read_seen_reg   <= 1'b0;
        end else if (step) begin
            config_low_reg  <= config_low_next;
            config_high_reg <= config_high_next;
            output_data_reg <= output_data_next;
            lock_bits_reg   <= lock_bits_next;
            lock_key_reg    <= lock_key_next;
            key_phase_reg   <= key_phase_next;
            read_seen_reg   <= read_seen_next;
        end
    end

    `GPL_ASSERT_NEXT(a_lock_sticky, aclk, aresetn, lock_key_reg, lock_key_reg,
        "lock key cleared without reset")
    `GPL_ASSERT_NEXT(a_lock_bits_frozen, aclk, aresetn, lock_key_reg,
        $stable(lock_bits_reg), "lock bits changed while locked")
    `GPL_ASSERT_SAME(a_phase_idle_locked, aclk, aresetn, lock_key_reg,
        key_phase_reg == KEY_IDLE, "key sequence in progress while locked")
    `GPL_ASSERT_NEXT(a_hold_without_step, aclk, aresetn, !step,
        $stable(output_data_reg) && $stable(config_low_reg) && $stable(config_high_reg),
        "port state changed without an item")

endmodule

`default_nettype wire

### rtl/gpio_port_with_config_lock_top.sv
// Top level of the 16-pin GPIO port with configuration lock: input and
// result registers around gpl_core. Depends on gpl_pkg and gpl_core.
// An accepted item waits in the input register; its result is registered
// into the result register once that is free or draining, raising m_valid.
// Throughput: one item per cycle; the input register refills while the
// result register drains, and both stall together only when m_ready is low.
// Reset: synchronous, active low; config words return to 0x44444444,
// output data, lock bits, lock key and the key sequence to zero.
`default_nettype none

module gpio_port_with_config_lock_top
    import gpl_pkg::*;
(
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     s_valid,
    output logic          s_ready,
    input  wire gpl_in_t  s_item,
    output logic          m_valid,
    input  wire logic     m_ready,
    output gpl_out_t      m_item
);

    // Input register: holds one accepted item until it is processed.
    logic     in_valid_reg, in_valid_next;
    gpl_in_t  in_item_reg;

    // Result register: holds one result until the downstream takes it.
    logic     out_valid_reg, out_valid_next;
    gpl_out_t out_item_reg;

    gpl_out_t core_result;
    logic     advance;
    logic     accept;

    // An item moves from the input register into the result register, and
    // updates the port state, whenever the result register is free or is
    // being emptied in this same cycle.
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign accept  = s_valid && s_ready;

    gpl_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step    (advance),
        .item    (in_item_reg),
        .result  (core_result)
    );

    always_comb begin
        if (accept) begin
            in_valid_next = 1'b1;
        end else if (advance) begin
            in_valid_next = 1'b0;
        end else begin
            in_valid_next = in_valid_reg;
        end

        if (advance) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset; their valid bits qualify them.
    always_ff @(posedge aclk) begin
        if (accept) begin
            in_item_reg <= s_item;
        end
        if (advance) begin
            out_item_reg <= core_result;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_item  = out_item_reg;

endmodule

`default_nettype wire
